FILE: hdl/vgatc_pkg.sv
`default_nettype none

package vgatc_pkg;

  // Counter and tally widths.
  localparam int CNT_W   = 16;
  localparam int TALLY_W = 32;
  localparam int GEOM_W  = 12;
  // Comparison width for the visible window: wide enough for the counter and
  // for a start plus a visible length (two 12-bit sums).
  localparam int WIN_W   = (CNT_W > GEOM_W + 2) ? CNT_W : GEOM_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TALLY_W-1:0] tally_t;
  typedef logic [GEOM_W-1:0]  geom_t;
  typedef logic [WIN_W-1:0]   win_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_H_TOTAL       = 3'd0,
    REG_H_SYNC_WIDTH  = 3'd1,
    REG_H_ACTIVE      = 3'd2,
    REG_V_TOTAL       = 3'd3,
    REG_V_SYNC_WIDTH  = 3'd4,
    REG_V_ACTIVE      = 3'd5,
    REG_BACK_PORCHES  = 3'd6,
    REG_SYNC_POLARITY = 3'd7
  } cfg_idx_e;

  localparam geom_t            RST_H_TOTAL       = 12'd800;
  localparam geom_t            RST_H_SYNC_WIDTH  = 12'd96;
  localparam geom_t            RST_H_ACTIVE      = 12'd640;
  localparam geom_t            RST_V_TOTAL       = 12'd525;
  localparam geom_t            RST_V_SYNC_WIDTH  = 12'd2;
  localparam geom_t            RST_V_ACTIVE      = 12'd480;
  localparam logic [23:0]      RST_BACK_PORCHES  = 24'd135216;
  localparam logic [1:0]       RST_SYNC_POLARITY = 2'd3;

  // Error mask bit positions.
  localparam int ERR_LINES = 0;
  localparam int ERR_PIXELS = 1;
  localparam int ERR_HSYNC = 2;
  localparam int ERR_VSYNC = 3;

  typedef struct packed {
    geom_t       h_total;
    geom_t       h_sync_width;
    geom_t       h_active;
    geom_t       v_total;
    geom_t       v_sync_width;
    geom_t       v_active;
    logic [23:0] back_porches;
    logic [1:0]  sync_polarity;
  } cfg_t;

  typedef struct packed {
    logic       hsync_level;
    logic       vsync_level;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic        pixel_write;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] pixel_rgb;
    logic        frame_done;
    logic [3:0]  error_mask;
    logic [31:0] error_total;
    logic [31:0] frame_total;
  } out_item_t;

  // Counter increment that holds at the maximum.
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/vgatc_in_if.sv
`default_nettype none

interface vgatc_in_if;
  logic                 valid;
  logic                 ready;
  vgatc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/vgatc_out_if.sv
`default_nettype none

interface vgatc_out_if;
  logic                  valid;
  logic                  ready;
  vgatc_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/vgatc_cfg_if.sv
`default_nettype none

interface vgatc_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [vgatc_pkg::CFG_IDX_W-1:0]        index;
  logic [vgatc_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/vga_sync_timing_checker_capture_top.sv
// Channel   Direction  Beat contents
// in_ch     sink       raw hsync/vsync levels and three 8-bit RGB components
// out_ch    source     pixel write, x, y, rgb, frame done, error mask and tallies
// cfg_ch    sink       register index (3 bits) and write data (24 bits)
//
// Every input beat yields exactly one output beat via the input and output
// registers; a beat can be accepted in every cycle unless out_ch stalls, so
// one sample per clock. The rate is set by the single evaluation stage between
// the two registers; the stage updates the timing state once per beat.
// Reset is synchronous and active high; it returns each control register to its
// documented value and clears all timing state. A stall on out_ch holds the
// output register, which holds the input register, which drops in_ch.ready.
// Configuration writes are accepted in any cycle (cfg_ch.ready stays high).

`default_nettype none

module vga_sync_timing_checker_capture_top (
  input  logic               clk,
  input  logic               rst,
  vgatc_in_if.sink           in_ch,
  vgatc_out_if.source        out_ch,
  vgatc_cfg_if.sink          cfg_ch
);

  // Configuration registers. A write never disturbs the timing state; a new
  // polarity applies to the very next sample evaluated.
  vgatc_pkg::cfg_t cfg;

  // Input register: one captured sample waiting for evaluation.
  logic                 in_vld;
  vgatc_pkg::in_item_t  in_item;

  // Output register: one finished result waiting to be taken.
  logic                 out_vld;
  vgatc_pkg::out_item_t out_item;

  vgatc_pkg::out_item_t res;
  logic                 adv;

  // The sample moves through evaluation whenever the output slot is free or
  // is being emptied in this same cycle.
  assign adv          = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready  = !in_vld || adv;
  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_item;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.h_total       <= vgatc_pkg::RST_H_TOTAL;
      cfg.h_sync_width  <= vgatc_pkg::RST_H_SYNC_WIDTH;
      cfg.h_active      <= vgatc_pkg::RST_H_ACTIVE;
      cfg.v_total       <= vgatc_pkg::RST_V_TOTAL;
      cfg.v_sync_width  <= vgatc_pkg::RST_V_SYNC_WIDTH;
      cfg.v_active      <= vgatc_pkg::RST_V_ACTIVE;
      cfg.back_porches  <= vgatc_pkg::RST_BACK_PORCHES;
      cfg.sync_polarity <= vgatc_pkg::RST_SYNC_POLARITY;
    end else if (cfg_ch.valid) begin
      unique case (vgatc_pkg::cfg_idx_e'(cfg_ch.index))
        vgatc_pkg::REG_H_TOTAL:       cfg.h_total       <= cfg_ch.data[11:0];
        vgatc_pkg::REG_H_SYNC_WIDTH:  cfg.h_sync_width  <= cfg_ch.data[11:0];
        vgatc_pkg::REG_H_ACTIVE:      cfg.h_active      <= cfg_ch.data[11:0];
        vgatc_pkg::REG_V_TOTAL:       cfg.v_total       <= cfg_ch.data[11:0];
        vgatc_pkg::REG_V_SYNC_WIDTH:  cfg.v_sync_width  <= cfg_ch.data[11:0];
        vgatc_pkg::REG_V_ACTIVE:      cfg.v_active      <= cfg_ch.data[11:0];
        vgatc_pkg::REG_BACK_PORCHES:  cfg.back_porches  <= cfg_ch.data[23:0];
        vgatc_pkg::REG_SYNC_POLARITY: cfg.sync_polarity <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= res;
    end
  end

  // Sync edge detection, counters, checks and pixel window.
  vgatc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .cfg  (cfg),
    .item (in_item),
    .res  (res)
  );

endmodule

`default_nettype wire

FILE: hdl/vgatc_core.sv
`default_nettype none

// Timing state and per-sample evaluation. The result is combinational from
// the state and the registered sample; the state advances when step is high.
module vgatc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  vgatc_pkg::cfg_t      cfg,
  input  vgatc_pkg::in_item_t  item,
  output vgatc_pkg::out_item_t res
);

  logic last_hsync, last_vsync;
  logic hsync_seen, vsync_seen, hpulse_on, vpulse_on, frame_written;
  vgatc_pkg::cnt_t   pixel_count, line_count, hpulse_count, vpulse_count;
  vgatc_pkg::tally_t error_tally, frame_tally;

  logic hsync_seen_next, vsync_seen_next, hpulse_on_next, vpulse_on_next;
  logic frame_written_next;
  vgatc_pkg::cnt_t   pixel_count_next, line_count_next;
  vgatc_pkg::cnt_t   hpulse_count_next, vpulse_count_next;
  vgatc_pkg::tally_t error_tally_next, frame_tally_next;

  logic h_now, v_now, h_prev, v_prev;
  logic [3:0] mask;
  logic [2:0] errs;
  logic done, wr;
  vgatc_pkg::win_t xs, ys, xe, ye, pc_w, lc_w, dx, dy;

  always_comb begin
    h_now  = cfg.sync_polarity[0] ? ~item.hsync_level : item.hsync_level;
    v_now  = cfg.sync_polarity[1] ? ~item.vsync_level : item.vsync_level;
    h_prev = cfg.sync_polarity[0] ? ~last_hsync : last_hsync;
    v_prev = cfg.sync_polarity[1] ? ~last_vsync : last_vsync;

    hsync_seen_next    = hsync_seen;
    vsync_seen_next    = vsync_seen;
    hpulse_on_next     = hpulse_on;
    vpulse_on_next     = vpulse_on;
    frame_written_next = frame_written;
    pixel_count_next   = pixel_count;
    line_count_next    = line_count;
    hpulse_count_next  = hpulse_count;
    vpulse_count_next  = vpulse_count;
    frame_tally_next   = frame_tally;
    mask = '0;
    done = 1'b0;

    // Vertical sync assert: close the frame.
    if (!v_prev && v_now) begin
      if (vsync_seen && (line_count != vgatc_pkg::CNT_W'(cfg.v_total))) begin
        mask[vgatc_pkg::ERR_LINES] = 1'b1;
      end
      if (frame_written) begin
        done = 1'b1;
        frame_tally_next = frame_tally + vgatc_pkg::tally_t'(1);
        frame_written_next = 1'b0;
      end
      vsync_seen_next   = 1'b1;
      vpulse_on_next    = 1'b1;
      vpulse_count_next = '0;
      line_count_next   = '0;
    end

    // Horizontal sync assert: close the line.
    if (!h_prev && h_now) begin
      if (hsync_seen && (pixel_count != vgatc_pkg::CNT_W'(cfg.h_total))) begin
        mask[vgatc_pkg::ERR_PIXELS] = 1'b1;
      end
      hsync_seen_next   = 1'b1;
      hpulse_on_next    = 1'b1;
      hpulse_count_next = '0;
      pixel_count_next  = '0;
      if (vsync_seen_next) begin
        line_count_next = vgatc_pkg::sat_inc(line_count_next);
        if (vpulse_on_next) begin
          vpulse_count_next = vgatc_pkg::sat_inc(vpulse_count_next);
        end
      end
    end

    if (h_prev && !h_now) begin
      if (hpulse_count != vgatc_pkg::CNT_W'(cfg.h_sync_width)) begin
        mask[vgatc_pkg::ERR_HSYNC] = 1'b1;
      end
      hpulse_on_next = 1'b0;
    end

    // The vsync width may already include a line counted this sample.
    if (v_prev && !v_now) begin
      if (vpulse_count_next != vgatc_pkg::CNT_W'(cfg.v_sync_width)) begin
        mask[vgatc_pkg::ERR_VSYNC] = 1'b1;
      end
      vpulse_on_next = 1'b0;
    end

    errs = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
    error_tally_next = error_tally + vgatc_pkg::TALLY_W'(errs);

    // Visible window, compared at full width.
    xs   = vgatc_pkg::WIN_W'(cfg.h_sync_width) + vgatc_pkg::WIN_W'(cfg.back_porches[11:0]);
    ys   = vgatc_pkg::WIN_W'(cfg.v_sync_width) + vgatc_pkg::WIN_W'(cfg.back_porches[23:12]);
    xe   = xs + vgatc_pkg::WIN_W'(cfg.h_active);
    ye   = ys + vgatc_pkg::WIN_W'(cfg.v_active);
    pc_w = vgatc_pkg::WIN_W'(pixel_count_next);
    lc_w = vgatc_pkg::WIN_W'(line_count_next);
    dx   = pc_w - xs;
    dy   = lc_w - ys;
    wr   = hsync_seen_next && vsync_seen_next && (pc_w >= xs) && (pc_w < xe) &&
           (lc_w >= ys) && (lc_w < ye);
    if (wr) begin
      frame_written_next = 1'b1;
    end

    if (hpulse_on_next) begin
      hpulse_count_next = vgatc_pkg::sat_inc(hpulse_count_next);
    end
    if (hsync_seen_next) begin
      pixel_count_next = vgatc_pkg::sat_inc(pixel_count_next);
    end

    res.pixel_write = wr;
    res.pixel_x     = wr ? dx[11:0] : '0;
    res.pixel_y     = wr ? dy[11:0] : '0;
    res.pixel_rgb   = wr ? {item.red_in, item.green_in, item.blue_in} : '0;
    res.frame_done  = done;
    res.error_mask  = mask;
    res.error_total = 32'(error_tally_next);
    res.frame_total = 32'(frame_tally_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_hsync    <= 1'b1;
      last_vsync    <= 1'b1;
      hsync_seen    <= 1'b0;
      vsync_seen    <= 1'b0;
      hpulse_on     <= 1'b0;
      vpulse_on     <= 1'b0;
      frame_written <= 1'b0;
      pixel_count   <= '0;
      line_count    <= '0;
      hpulse_count  <= '0;
      vpulse_count  <= '0;
      error_tally   <= '0;
      frame_tally   <= '0;
    end else if (step) begin
      last_hsync    <= item.hsync_level;
      last_vsync    <= item.vsync_level;
      hsync_seen    <= hsync_seen_next;
      vsync_seen    <= vsync_seen_next;
      hpulse_on     <= hpulse_on_next;
      vpulse_on     <= vpulse_on_next;
      frame_written <= frame_written_next;
      pixel_count   <= pixel_count_next;
      line_count    <= line_count_next;
      hpulse_count  <= hpulse_count_next;
      vpulse_count  <= vpulse_count_next;
      error_tally   <= error_tally_next;
      frame_tally   <= frame_tally_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vgatc_checker.sv
`default_nettype none

module vgatc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pixel_write,
  input logic [11:0] pixel_x,
  input logic [11:0] pixel_y,
  input logic [23:0] pixel_rgb,
  input logic        frame_done,
  input logic [3:0]  error_mask,
  input logic [31:0] error_total,
  input logic [31:0] frame_total
);

  logic        have_prev;
  logic [31:0] prev_error_total;
  logic [31:0] prev_frame_total;
  logic        out_beat;

  assign out_beat = out_valid && out_ready;

  // Tallies seen on the previous output beat; they start from zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev        <= 1'b1;
      prev_error_total <= '0;
      prev_frame_total <= '0;
    end else if (out_beat) begin
      prev_error_total <= error_total;
      prev_frame_total <= frame_total;
    end
  end

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixel_write) |->
      (pixel_x == 12'd0 && pixel_y == 12'd0 && pixel_rgb == 24'd0))
    else $error("non-write beat carries pixel data");

  a_frame_tally: assert property (@(posedge clk) disable iff (rst)
    (out_beat && have_prev) |-> (frame_total == prev_frame_total + 32'(frame_done)))
    else $error("frame total does not follow frame done");

  a_error_tally: assert property (@(posedge clk) disable iff (rst)
    (out_beat && have_prev) |->
      (error_total == prev_error_total + 32'($countones(error_mask))))
    else $error("error total does not follow error mask");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output beat withdrawn while stalled");

endmodule

bind vga_sync_timing_checker_capture_top vgatc_checker u_vgatc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_write (out_ch.data.pixel_write),
  .pixel_x     (out_ch.data.pixel_x),
  .pixel_y     (out_ch.data.pixel_y),
  .pixel_rgb   (out_ch.data.pixel_rgb),
  .frame_done  (out_ch.data.frame_done),
  .error_mask  (out_ch.data.error_mask),
  .error_total (out_ch.data.error_total),
  .frame_total (out_ch.data.frame_total)
);

`default_nettype wire
